FILE: sv/lbm_pkg.sv
// ----------------------------------------------------------------------------
// lbm_pkg
// Shared types, constants and saturating Q4.28 arithmetic for the D2Q9
// regularized collision pipeline.
// ----------------------------------------------------------------------------
package lbm_pkg;

  // number format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 28;
  localparam int EXT_BITS  = 72;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [EXT_BITS-1:0]  ext_t;

  // value plus clip flag
  typedef struct packed {
    word_t v;
    logic  c;
  } res_t;

  localparam word_t WMAX = 32'sh7FFFFFFF;
  localparam word_t WMIN = 32'sh80000000;
  localparam logic [63:0] WMAX_U = 64'h000000007FFFFFFF;
  localparam logic [63:0] WMIN_MAG = 64'h0000000080000000;

  localparam word_t ONE   = word_t'(1 << FRAC_BITS);
  localparam word_t THIRD = word_t'(((1 << FRAC_BITS) + 1) / 3);
  localparam word_t TWO3  = word_t'(((2 << FRAC_BITS) + 1) / 3);

  // reciprocals for exact unsigned 32-bit division by 3 and 9
  localparam logic [31:0] RECIP3   = 32'hAAAAAAAB;
  localparam logic [31:0] RECIP9   = 32'h38E38E39;
  localparam int          RECIP_SH = 33;

  // lattice directions
  localparam int DIR_X [9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  // shift of the divisor per direction class (rest, x axis, y axis, diagonal)
  localparam int CLS_SH [4] = '{0, 2, 2, 4};

  // omega divider
  localparam int QUO_BITS   = 30;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = QUO_BITS / DIV_STEP;
  localparam int DIV_BITS   = 34;

  // configuration
  localparam int          ADDR_BITS  = 2;
  localparam logic [1:0]  ADDR_VISC  = 2'd0;
  localparam logic [30:0] VISC_RESET = 31'd26843546;

  typedef struct packed {
    logic [30:0]  density;
    logic [30:0]  temperature;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] moment_xx;
    logic signed [31:0] moment_xy;
    logic signed [31:0] moment_yy;
    logic signed [31:0] corr_xx;
    logic signed [31:0] corr_yy;
  } node_t;

  typedef struct packed {
    logic signed [31:0] pop_0;
    logic signed [31:0] pop_1;
    logic signed [31:0] pop_2;
    logic signed [31:0] pop_3;
    logic signed [31:0] pop_4;
    logic signed [31:0] pop_5;
    logic signed [31:0] pop_6;
    logic signed [31:0] pop_7;
    logic signed [31:0] pop_8;
    logic               saturated;
  } pops_t;

  // direction class: rest, x axis, y axis, diagonal
  function automatic int dir_cls(input int k);
    int r;
    if (k == 0) r = 0;
    else if (k == 1 || k == 3) r = 1;
    else if (k == 2 || k == 4) r = 2;
    else r = 3;
    return r;
  endfunction

  // hermite weight along one axis
  function automatic int hcoef(input int c);
    return (c != 0) ? 2 : -1;
  endfunction

  function automatic ext_t ext(input word_t a);
    return ext_t'(a);
  endfunction

  // clip a wide value to the word range
  function automatic res_t sat_w(input ext_t x);
    res_t r;
    if (x > ext_t'(WMAX)) begin
      r.v = WMAX;
      r.c = 1'b1;
    end else if (x < ext_t'(WMIN)) begin
      r.v = WMIN;
      r.c = 1'b1;
    end else begin
      r.v = x[WORD_BITS-1:0];
      r.c = 1'b0;
    end
    return r;
  endfunction

  function automatic res_t add_s(input word_t a, input word_t b);
    return sat_w(ext(a) + ext(b));
  endfunction

  function automatic res_t neg_s(input word_t a);
    res_t r;
    if (a == WMIN) begin
      r.v = WMAX;
      r.c = 1'b1;
    end else begin
      r.v = -a;
      r.c = 1'b0;
    end
    return r;
  endfunction

  // subtract as negate then add, each clipping on its own
  function automatic res_t sub_s(input word_t a, input word_t b);
    res_t n;
    res_t r;
    n = neg_s(b);
    r = add_s(a, n.v);
    r.c = r.c | n.c;
    return r;
  endfunction

  // exact product with a small integer, then clip
  function automatic res_t muli_s(input word_t a, input int n);
    return sat_w(ext(a) * ext_t'(n));
  endfunction

  // a + b*n with both clips
  function automatic res_t add_mi(input word_t a, input word_t b, input int n);
    res_t m;
    res_t r;
    m = muli_s(b, n);
    r = add_s(a, m.v);
    r.c = r.c | m.c;
    return r;
  endfunction

  // a*na + b*nb with all clips
  function automatic res_t muladd_s(input word_t a, input int na, input word_t b,
                                    input int nb);
    res_t ma;
    res_t mb;
    res_t r;
    ma = muli_s(a, na);
    mb = muli_s(b, nb);
    r = add_s(ma.v, mb.v);
    r.c = r.c | ma.c | mb.c;
    return r;
  endfunction

  // fixed point product, rounded half away from zero, then clip
  function automatic res_t mulq_s(input word_t a, input word_t b);
    logic signed [63:0] p;
    logic [63:0] mag;
    logic [63:0] rnd;
    logic [63:0] nr;
    res_t r;
    p = a * b;
    mag = p[63] ? (64'd0 - $unsigned(p)) : $unsigned(p);
    rnd = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    nr = 64'd0 - rnd;
    if (!p[63]) begin
      if (rnd > WMAX_U) begin
        r.v = WMAX;
        r.c = 1'b1;
      end else begin
        r.v = rnd[WORD_BITS-1:0];
        r.c = 1'b0;
      end
    end else begin
      if (rnd > WMIN_MAG) begin
        r.v = WMIN;
        r.c = 1'b1;
      end else begin
        r.v = nr[WORD_BITS-1:0];
        r.c = 1'b0;
      end
    end
    return r;
  endfunction

  // divide by odd*2^sh, odd in 1, 3, 9, rounding half away from zero
  function automatic res_t divc_s(input word_t a, input int sh, input int odd);
    logic [WORD_BITS:0]   mag;
    logic [WORD_BITS-1:0] n;
    logic [WORD_BITS-1:0] t;
    logic [63:0]          pr;
    logic [WORD_BITS-1:0] q;
    logic [WORD_BITS:0]   nq;
    res_t r;
    mag = 33'(a);
    if (a[WORD_BITS-1]) mag = 33'd0 - mag;
    n = 32'(mag + 33'((odd << sh) >> 1));
    t = n >> sh;
    pr = 64'd0;
    if (odd == 3) begin
      pr = 64'(t) * 64'(RECIP3);
      q = 32'(pr >> RECIP_SH);
    end else if (odd == 9) begin
      pr = 64'(t) * 64'(RECIP9);
      q = 32'(pr >> RECIP_SH);
    end else begin
      q = t;
    end
    nq = 33'(q);
    if (a[WORD_BITS-1]) nq = 33'd0 - nq;
    r.v = nq[WORD_BITS-1:0];
    r.c = 1'b0;
    return r;
  endfunction

endpackage

FILE: sv/lbm_d2q9_regularized_collision.sv
// ----------------------------------------------------------------------------
// lbm_d2q9_regularized_collision
// Regularized D2Q9 collision with temperature for one lattice node per cycle unless stalled.
// ----------------------------------------------------------------------------
// One node enters per clock cycle and its nine populations come out at the end
// of the pipeline; the pipeline stops as a whole only while a result in the output
// register is stalled. The latency is set by the relaxation rate omega, which
// is found by a 15-stage restoring divider retiring two quotient bits per
// stage; the equilibrium and regularization terms run alongside it in eight
// stages and wait in a delay line. The viscosity register sits at byte
// address 0 of the APB port and resets to 0.1 in Q4.28.
module lbm_d2q9_regularized_collision (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  node_valid,
  output logic                  node_stall,
  input  lbm_pkg::node_t        node,
  output logic                  pops_valid,
  input  logic                  pops_stall,
  output lbm_pkg::pops_t        pops,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [lbm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int DIV_START = 3;
  localparam int DIV_END   = DIV_START + lbm_pkg::DIV_STAGES;
  localparam int NSTG      = DIV_END + 3;
  localparam int DLY       = DIV_END - 8;

  typedef struct packed {
    lbm_pkg::word_t [8:0] feq;
    lbm_pkg::word_t [8:0] g1;
    lbm_pkg::word_t [3:0] hp;
    logic                 c;
  } tail_t;

  // configuration register
  logic [30:0] visc;

  always_ff @(posedge clk) begin
    if (rst) begin
      visc <= lbm_pkg::VISC_RESET;
    end else if (psel && penable && pwrite && paddr == lbm_pkg::ADDR_VISC) begin
      visc <= pwdata[30:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == lbm_pkg::ADDR_VISC) ? {1'b0, visc} : 32'd0;

  // pipeline advance and valid bits
  logic            en;
  logic [NSTG:1]   v;

  assign en = !(v[NSTG] && pops_stall);
  assign node_stall = !en;
  assign pops_valid = v[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NSTG-1:1], node_valid};
    end
  end

  // stage 1: squares, raw products, psi sums
  lbm_pkg::word_t rho_in, th_in;
  lbm_pkg::res_t  c1_uxx, c1_uyy, c1_uxy, c1_tca, c1_prt, c1_pa, c1_pb, c1_qa, c1_qb;
  lbm_pkg::res_t  c1_ps [4];

  assign rho_in = lbm_pkg::word_t'({1'b0, node.density});
  assign th_in  = lbm_pkg::word_t'({1'b0, node.temperature});

  always_comb begin
    c1_uxx = lbm_pkg::mulq_s(node.vel_x, node.vel_x);
    c1_uyy = lbm_pkg::mulq_s(node.vel_y, node.vel_y);
    c1_uxy = lbm_pkg::mulq_s(node.vel_x, node.vel_y);
    c1_tca = lbm_pkg::sub_s(th_in, lbm_pkg::ONE);
    c1_prt = lbm_pkg::mulq_s(rho_in, th_in);
    c1_pa  = lbm_pkg::mulq_s(node.vel_y, node.moment_xx);
    c1_pb  = lbm_pkg::mulq_s(node.vel_x, node.moment_xy);
    c1_qa  = lbm_pkg::mulq_s(node.vel_x, node.moment_yy);
    c1_qb  = lbm_pkg::mulq_s(node.vel_y, node.moment_xy);
    c1_ps[0] = lbm_pkg::muladd_s(node.corr_xx, -1, node.corr_yy, -1);
    c1_ps[1] = lbm_pkg::muladd_s(node.corr_xx, 2, node.corr_yy, -1);
    c1_ps[2] = lbm_pkg::muladd_s(node.corr_xx, -1, node.corr_yy, 2);
    c1_ps[3] = lbm_pkg::muladd_s(node.corr_xx, 2, node.corr_yy, 2);
  end

  lbm_pkg::word_t s1_rho, s1_ux, s1_uy, s1_axx, s1_axy, s1_ayy;
  lbm_pkg::word_t s1_uxx, s1_uyy, s1_uxy, s1_tca, s1_prt, s1_pa, s1_pb, s1_qa, s1_qb;
  lbm_pkg::word_t s1_ps [4];
  logic           s1_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rho <= rho_in;
      s1_ux  <= node.vel_x;
      s1_uy  <= node.vel_y;
      s1_axx <= node.moment_xx;
      s1_axy <= node.moment_xy;
      s1_ayy <= node.moment_yy;
      s1_uxx <= c1_uxx.v;
      s1_uyy <= c1_uyy.v;
      s1_uxy <= c1_uxy.v;
      s1_tca <= c1_tca.v;
      s1_prt <= c1_prt.v;
      s1_pa  <= c1_pa.v;
      s1_pb  <= c1_pb.v;
      s1_qa  <= c1_qa.v;
      s1_qb  <= c1_qb.v;
      for (int k = 0; k < 4; k++) s1_ps[k] <= c1_ps[k].v;
      s1_c <= c1_uxx.c | c1_uyy.c | c1_uxy.c | c1_tca.c | c1_prt.c | c1_pa.c |
              c1_pb.c | c1_qa.c | c1_qb.c | c1_ps[0].c | c1_ps[1].c |
              c1_ps[2].c | c1_ps[3].c;
    end
  end

  // stage 2: tc, pressure, P and Q, half psi
  lbm_pkg::res_t c2_tc, c2_pr, c2_p, c2_q;
  lbm_pkg::res_t c2_hp [4];

  always_comb begin
    c2_tc = lbm_pkg::divc_s(s1_tca, 0, 3);
    c2_pr = lbm_pkg::divc_s(s1_prt, 0, 3);
    c2_p  = lbm_pkg::add_mi(s1_pa, s1_pb, 2);
    c2_q  = lbm_pkg::add_mi(s1_qa, s1_qb, 2);
    for (int k = 0; k < 4; k++) c2_hp[k] = lbm_pkg::divc_s(s1_ps[k], lbm_pkg::CLS_SH[k], 3);
  end

  lbm_pkg::word_t s2_rho, s2_ux, s2_uy, s2_axx, s2_axy, s2_ayy;
  lbm_pkg::word_t s2_uxx, s2_uyy, s2_uxy, s2_tc, s2_pr, s2_p, s2_q;
  lbm_pkg::word_t s2_hp [4];
  logic           s2_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rho <= s1_rho;
      s2_ux  <= s1_ux;
      s2_uy  <= s1_uy;
      s2_axx <= s1_axx;
      s2_axy <= s1_axy;
      s2_ayy <= s1_ayy;
      s2_uxx <= s1_uxx;
      s2_uyy <= s1_uyy;
      s2_uxy <= s1_uxy;
      s2_tc  <= c2_tc.v;
      s2_pr  <= c2_pr.v;
      s2_p   <= c2_p.v;
      s2_q   <= c2_q.v;
      for (int k = 0; k < 4; k++) s2_hp[k] <= c2_hp[k].v;
      s2_c <= s1_c | c2_p.c | c2_q.c;
    end
  end

  // stage 3: second moments of velocity, R products, divider setup
  lbm_pkg::res_t c3_axx, c3_ayy, c3_tmx, c3_tmy, c3_ra, c3_rb;

  always_comb begin
    c3_axx = lbm_pkg::add_s(s2_uxx, s2_tc);
    c3_ayy = lbm_pkg::add_s(s2_uyy, s2_tc);
    c3_tmx = lbm_pkg::sub_s(s2_tc, s2_uxx);
    c3_tmy = lbm_pkg::sub_s(s2_tc, s2_uyy);
    c3_ra  = lbm_pkg::mulq_s(s2_ux, s2_q);
    c3_rb  = lbm_pkg::mulq_s(s2_uy, s2_p);
  end

  lbm_pkg::word_t s3_rho, s3_ux, s3_uy, s3_axx_m, s3_axy, s3_ayy_m, s3_uxy, s3_p, s3_q;
  lbm_pkg::word_t s3_axx, s3_ayy, s3_tmx, s3_tmy, s3_ra, s3_rb;
  lbm_pkg::word_t s3_hp [4];
  logic           s3_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rho   <= s2_rho;
      s3_ux    <= s2_ux;
      s3_uy    <= s2_uy;
      s3_axx_m <= s2_axx;
      s3_axy   <= s2_axy;
      s3_ayy_m <= s2_ayy;
      s3_uxy   <= s2_uxy;
      s3_p     <= s2_p;
      s3_q     <= s2_q;
      s3_axx   <= c3_axx.v;
      s3_ayy   <= c3_ayy.v;
      s3_tmx   <= c3_tmx.v;
      s3_tmy   <= c3_tmy.v;
      s3_ra    <= c3_ra.v;
      s3_rb    <= c3_rb.v;
      for (int k = 0; k < 4; k++) s3_hp[k] <= s2_hp[k];
      s3_c <= s2_c | c3_axx.c | c3_ayy.c | c3_tmx.c | c3_tmy.c | c3_ra.c | c3_rb.c;
    end
  end

  // omega divider: floor(2p * 2^28 / (2mu + p)), two quotient bits per stage
  logic [lbm_pkg::DIV_BITS-1:0] dv_r [lbm_pkg::DIV_STAGES+1];
  logic [lbm_pkg::DIV_BITS-1:0] dv_d [lbm_pkg::DIV_STAGES+1];
  logic [lbm_pkg::QUO_BITS-1:0] dv_q [lbm_pkg::DIV_STAGES+1];
  logic                         dv_z [lbm_pkg::DIV_STAGES+1];
  logic [1:0]                   dv_nl;
  logic [lbm_pkg::DIV_BITS-1:0] dv_r_next [lbm_pkg::DIV_STAGES+1];
  logic [lbm_pkg::QUO_BITS-1:0] dv_q_next [lbm_pkg::DIV_STAGES+1];
  logic [lbm_pkg::DIV_BITS-1:0] d_init;

  assign d_init = {2'b00, visc, 1'b0} + {2'b00, s2_pr};

  always_comb begin
    logic [lbm_pkg::DIV_BITS-1:0] r;
    logic [lbm_pkg::QUO_BITS-1:0] q;
    logic                         bitin;
    dv_r_next[0] = '0;
    dv_q_next[0] = '0;
    for (int j = 1; j <= lbm_pkg::DIV_STAGES; j++) begin
      r = dv_r[j-1];
      q = dv_q[j-1];
      for (int b = 0; b < lbm_pkg::DIV_STEP; b++) begin
        bitin = (j == 1) ? dv_nl[1-b] : 1'b0;
        r = {r[lbm_pkg::DIV_BITS-2:0], bitin};
        if (r >= dv_d[j-1]) begin
          r = r - dv_d[j-1];
          q = {q[lbm_pkg::QUO_BITS-2:0], 1'b1};
        end else begin
          q = {q[lbm_pkg::QUO_BITS-2:0], 1'b0};
        end
      end
      dv_r_next[j] = r;
      dv_q_next[j] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= {3'b000, s2_pr[31:1]};
      dv_d[0] <= d_init;
      dv_q[0] <= '0;
      dv_z[0] <= (d_init == '0);
      dv_nl   <= {s2_pr[0], 1'b0};
      for (int j = 1; j <= lbm_pkg::DIV_STAGES; j++) begin
        dv_r[j] <= dv_r_next[j];
        dv_d[j] <= dv_d[j-1];
        dv_q[j] <= dv_q_next[j];
        dv_z[j] <= dv_z[j-1];
      end
    end
  end

  // stage 4: hermite factors, R terms
  lbm_pkg::res_t c4_hx0, c4_hy0, c4_xv1, c4_yv1, c4_rab, c4_r1, c4_rc, c4_rd, c4_re0, c4_re;

  always_comb begin
    c4_hx0 = lbm_pkg::add_s(lbm_pkg::THIRD, s3_axx);
    c4_hy0 = lbm_pkg::add_s(lbm_pkg::THIRD, s3_ayy);
    c4_xv1 = lbm_pkg::sub_s(lbm_pkg::TWO3, s3_axx);
    c4_yv1 = lbm_pkg::sub_s(lbm_pkg::TWO3, s3_ayy);
    c4_rab = lbm_pkg::add_s(s3_ra, s3_rb);
    c4_r1  = lbm_pkg::muli_s(c4_rab.v, 2);
    c4_rc  = lbm_pkg::mulq_s(s3_tmx, s3_ayy_m);
    c4_rd  = lbm_pkg::mulq_s(s3_tmy, s3_axx_m);
    c4_re0 = lbm_pkg::mulq_s(s3_uxy, s3_axy);
    c4_re  = lbm_pkg::muli_s(c4_re0.v, 4);
  end

  lbm_pkg::word_t s4_rho, s4_ux, s4_uy, s4_axx, s4_axy, s4_ayy, s4_p, s4_q;
  lbm_pkg::word_t s4_hx0, s4_hy0, s4_xv1, s4_yv1, s4_r1, s4_rc, s4_rd, s4_re;
  lbm_pkg::word_t s4_hp [4];
  logic           s4_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_rho <= s3_rho;
      s4_ux  <= s3_ux;
      s4_uy  <= s3_uy;
      s4_axx <= s3_axx_m;
      s4_axy <= s3_axy;
      s4_ayy <= s3_ayy_m;
      s4_p   <= s3_p;
      s4_q   <= s3_q;
      s4_hx0 <= c4_hx0.v;
      s4_hy0 <= c4_hy0.v;
      s4_xv1 <= c4_xv1.v;
      s4_yv1 <= c4_yv1.v;
      s4_r1  <= c4_r1.v;
      s4_rc  <= c4_rc.v;
      s4_rd  <= c4_rd.v;
      s4_re  <= c4_re.v;
      for (int k = 0; k < 4; k++) s4_hp[k] <= s3_hp[k];
      s4_c <= s3_c | c4_hx0.c | c4_hy0.c | c4_xv1.c | c4_yv1.c | c4_rab.c | c4_r1.c |
              c4_rc.c | c4_rd.c | c4_re0.c | c4_re.c;
    end
  end

  // stage 5: moving hermite factors, R sum
  lbm_pkg::res_t c5_xs0, c5_xs2, c5_ys0, c5_ys2, c5_xv0, c5_xv2, c5_yv0, c5_yv2;
  lbm_pkg::res_t c5_ra, c5_rb, c5_r;

  always_comb begin
    c5_xs0 = lbm_pkg::sub_s(s4_hx0, s4_ux);
    c5_xs2 = lbm_pkg::add_s(s4_hx0, s4_ux);
    c5_ys0 = lbm_pkg::sub_s(s4_hy0, s4_uy);
    c5_ys2 = lbm_pkg::add_s(s4_hy0, s4_uy);
    c5_xv0 = lbm_pkg::divc_s(c5_xs0.v, 1, 1);
    c5_xv2 = lbm_pkg::divc_s(c5_xs2.v, 1, 1);
    c5_yv0 = lbm_pkg::divc_s(c5_ys0.v, 1, 1);
    c5_yv2 = lbm_pkg::divc_s(c5_ys2.v, 1, 1);
    c5_ra  = lbm_pkg::add_s(s4_r1, s4_rc);
    c5_rb  = lbm_pkg::add_s(c5_ra.v, s4_rd);
    c5_r   = lbm_pkg::sub_s(c5_rb.v, s4_re);
  end

  lbm_pkg::word_t s5_rho, s5_axx, s5_axy, s5_ayy, s5_p, s5_q, s5_r;
  lbm_pkg::word_t s5_xv [3];
  lbm_pkg::word_t s5_yv [3];
  lbm_pkg::word_t s5_hp [4];
  logic           s5_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_rho   <= s4_rho;
      s5_axx   <= s4_axx;
      s5_axy   <= s4_axy;
      s5_ayy   <= s4_ayy;
      s5_p     <= s4_p;
      s5_q     <= s4_q;
      s5_r     <= c5_r.v;
      s5_xv[0] <= c5_xv0.v;
      s5_xv[1] <= s4_xv1;
      s5_xv[2] <= c5_xv2.v;
      s5_yv[0] <= c5_yv0.v;
      s5_yv[1] <= s4_yv1;
      s5_yv[2] <= c5_yv2.v;
      for (int k = 0; k < 4; k++) s5_hp[k] <= s4_hp[k];
      s5_c <= s4_c | c5_xs0.c | c5_xs2.c | c5_ys0.c | c5_ys2.c | c5_ra.c | c5_rb.c |
              c5_r.c;
    end
  end

  // stage 6: equilibrium factor products, first half of T
  lbm_pkg::word_t c6_xy [9];
  lbm_pkg::word_t c6_t [9];
  logic           c6_f;

  always_comb begin
    lbm_pkg::res_t m, t0, t1, t2, ta, tb;
    int hx, hy;
    c6_f = 1'b0;
    for (int k = 0; k < 9; k++) begin
      hx = lbm_pkg::hcoef(lbm_pkg::DIR_X[k]);
      hy = lbm_pkg::hcoef(lbm_pkg::DIR_Y[k]);
      m  = lbm_pkg::mulq_s(s5_xv[lbm_pkg::DIR_X[k] + 1], s5_yv[lbm_pkg::DIR_Y[k] + 1]);
      t0 = lbm_pkg::muli_s(s5_axx, 6 * hx);
      t1 = lbm_pkg::muli_s(s5_ayy, 6 * hy);
      t2 = lbm_pkg::muli_s(s5_axy, 36 * lbm_pkg::DIR_X[k] * lbm_pkg::DIR_Y[k]);
      ta = lbm_pkg::add_s(t0.v, t1.v);
      tb = lbm_pkg::add_s(ta.v, t2.v);
      c6_xy[k] = m.v;
      c6_t[k]  = tb.v;
      c6_f = c6_f | m.c | t0.c | t1.c | t2.c | ta.c | tb.c;
    end
  end

  lbm_pkg::word_t s6_rho, s6_p, s6_q, s6_r;
  lbm_pkg::word_t s6_xy [9];
  lbm_pkg::word_t s6_t [9];
  lbm_pkg::word_t s6_hp [4];
  logic           s6_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_rho <= s5_rho;
      s6_p   <= s5_p;
      s6_q   <= s5_q;
      s6_r   <= s5_r;
      for (int k = 0; k < 9; k++) begin
        s6_xy[k] <= c6_xy[k];
        s6_t[k]  <= c6_t[k];
      end
      for (int k = 0; k < 4; k++) s6_hp[k] <= s5_hp[k];
      s6_c <= s5_c | c6_f;
    end
  end

  // stage 7: equilibrium, second half of T
  lbm_pkg::word_t c7_feq [9];
  lbm_pkg::word_t c7_t [9];
  logic           c7_f;

  always_comb begin
    lbm_pkg::res_t fq, t3, t4, t5, ta, tb, tc;
    int hx, hy, cx, cy;
    c7_f = 1'b0;
    for (int k = 0; k < 9; k++) begin
      cx = lbm_pkg::DIR_X[k];
      cy = lbm_pkg::DIR_Y[k];
      hx = lbm_pkg::hcoef(cx);
      hy = lbm_pkg::hcoef(cy);
      fq = lbm_pkg::mulq_s(s6_rho, s6_xy[k]);
      t3 = lbm_pkg::muli_s(s6_p, 18 * hx * cy);
      t4 = lbm_pkg::muli_s(s6_q, 18 * hy * cx);
      t5 = lbm_pkg::muli_s(s6_r, 9 * hx * hy);
      ta = lbm_pkg::add_s(s6_t[k], t3.v);
      tb = lbm_pkg::add_s(ta.v, t4.v);
      tc = lbm_pkg::add_s(tb.v, t5.v);
      c7_feq[k] = fq.v;
      c7_t[k]   = tc.v;
      c7_f = c7_f | fq.c | t3.c | t4.c | t5.c | ta.c | tb.c | tc.c;
    end
  end

  lbm_pkg::word_t s7_feq [9];
  lbm_pkg::word_t s7_t [9];
  lbm_pkg::word_t s7_hp [4];
  logic           s7_c;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        s7_feq[k] <= c7_feq[k];
        s7_t[k]   <= c7_t[k];
      end
      for (int k = 0; k < 4; k++) s7_hp[k] <= s6_hp[k];
      s7_c <= s6_c | c7_f;
    end
  end

  // stage 8: regularized off-equilibrium part, then delay to meet omega
  tail_t c8_tail;

  always_comb begin
    lbm_pkg::res_t g;
    for (int k = 0; k < 9; k++) begin
      g = lbm_pkg::divc_s(s7_t[k], lbm_pkg::CLS_SH[lbm_pkg::dir_cls(k)], 9);
      c8_tail.feq[k] = s7_feq[k];
      c8_tail.g1[k]  = g.v;
    end
    for (int k = 0; k < 4; k++) c8_tail.hp[k] = s7_hp[k];
    c8_tail.c = s7_c;
  end

  tail_t dl [DLY+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= c8_tail;
      for (int i = 1; i <= DLY; i++) dl[i] <= dl[i-1];
    end
  end

  // stage 19: one minus omega
  lbm_pkg::word_t om;
  lbm_pkg::res_t  c19_om1;
  tail_t          c19_tail;

  assign om = dv_z[lbm_pkg::DIV_STAGES] ? '0 :
              lbm_pkg::word_t'({2'b00, dv_q[lbm_pkg::DIV_STAGES]});

  always_comb begin
    c19_om1 = lbm_pkg::sub_s(lbm_pkg::ONE, om);
    c19_tail = dl[DLY];
    c19_tail.c = dl[DLY].c | c19_om1.c;
  end

  lbm_pkg::word_t s19_om1;
  tail_t          s19_tail;

  always_ff @(posedge clk) begin
    if (en) begin
      s19_om1  <= c19_om1.v;
      s19_tail <= c19_tail;
    end
  end

  // stage 20: relaxed off-equilibrium part
  lbm_pkg::word_t c20_m [9];
  logic           c20_f;
  tail_t          c20_tail;

  always_comb begin
    lbm_pkg::res_t m;
    c20_f = 1'b0;
    for (int k = 0; k < 9; k++) begin
      m = lbm_pkg::mulq_s(s19_om1, s19_tail.g1[k]);
      c20_m[k] = m.v;
      c20_f = c20_f | m.c;
    end
    c20_tail = s19_tail;
    c20_tail.c = s19_tail.c | c20_f;
  end

  lbm_pkg::word_t s20_m [9];
  tail_t          s20_tail;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) s20_m[k] <= c20_m[k];
      s20_tail <= c20_tail;
    end
  end

  // output register: populations
  lbm_pkg::word_t c21_g [9];
  logic           c21_f;

  always_comb begin
    lbm_pkg::res_t a, g;
    c21_f = s20_tail.c;
    for (int k = 0; k < 9; k++) begin
      a = lbm_pkg::add_s(s20_tail.feq[k], s20_m[k]);
      g = lbm_pkg::add_s(a.v, s20_tail.hp[lbm_pkg::dir_cls(k)]);
      c21_g[k] = g.v;
      c21_f = c21_f | a.c | g.c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pops.pop_0     <= c21_g[0];
      pops.pop_1     <= c21_g[1];
      pops.pop_2     <= c21_g[2];
      pops.pop_3     <= c21_g[3];
      pops.pop_4     <= c21_g[4];
      pops.pop_5     <= c21_g[5];
      pops.pop_6     <= c21_g[6];
      pops.pop_7     <= c21_g[7];
      pops.pop_8     <= c21_g[8];
      pops.saturated <= c21_f;
    end
  end

`ifndef SYNTHESIS
  // valid bits move one stage per advancing cycle
  a_valid_shift: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(en) |-> v[NSTG] == $past(v[NSTG-1]))
    else $error("valid bit lost or invented at output stage");

  // divider remainder stays below divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    v[DIV_END] && !dv_z[lbm_pkg::DIV_STAGES] |->
      dv_r[lbm_pkg::DIV_STAGES] < dv_d[lbm_pkg::DIV_STAGES])
    else $error("omega divider remainder out of range");

  // relaxation factor lies within one minus [0, 2]
  a_om1_range: assert property (@(posedge clk) disable iff (rst)
    v[DIV_END+1] |-> s19_om1 >= -lbm_pkg::ONE && s19_om1 <= lbm_pkg::ONE)
    else $error("one minus omega out of range");
`endif

endmodule
